// ===== rtl/sdsh_pkg.sv =====
// ----------------------------------------------------------------------------
// SD SPI host sequencer package
// Types, phase codes and constants shared by the sequencer files.
// ----------------------------------------------------------------------------
package sdsh_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 512;
  localparam int unsigned IDLE_BYTES_DEF  = 10;

  typedef enum logic [2:0] {
    CMD_INIT  = 3'd0,
    CMD_READ  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_RX    = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_PRE, PH_GO, PH_IFC, PH_R7, PH_HCS, PH_HCS_T, PH_OCRC, PH_OCR,
    PH_PROBE, PH_LOOP, PH_LOOP_T, PH_BLEN, PH_RDC, PH_RDTOK, PH_RDDAT, PH_RDCRC,
    PH_WRC, PH_WRGAP, PH_WRTOK, PH_WRDAT, PH_WRCRC, PH_WRRSP, PH_BUSY, PH_BUSY_T
  } phase_t;

  typedef enum logic [1:0] {
    REG_INIT_POLL  = 2'd0,
    REG_TOKEN_POLL = 2'd1,
    REG_BUSY_POLL  = 2'd2,
    REG_RESP_POLL  = 2'd3
  } reg_idx_t;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_MMC    = 3'd1;
  localparam logic [2:0] KIND_SD1    = 3'd2;
  localparam logic [2:0] KIND_SD2_BY = 3'd3;
  localparam logic [2:0] KIND_SD2_BL = 3'd4;

  localparam logic [7:0] CODE_CMD0   = 8'h40;
  localparam logic [7:0] CODE_CMD8   = 8'h48;
  localparam logic [7:0] CODE_CMD1   = 8'h41;
  localparam logic [7:0] CODE_CMD16  = 8'h50;
  localparam logic [7:0] CODE_CMD17  = 8'h51;
  localparam logic [7:0] CODE_CMD24  = 8'h58;
  localparam logic [7:0] CODE_CMD58  = 8'h7A;
  localparam logic [7:0] CODE_ACMD41 = 8'hE9;
  localparam logic [7:0] CODE_CMD55  = 8'h77;
  localparam logic [31:0] ARG_IFC    = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS    = 32'h4000_0000;
  localparam logic [7:0] CRC_CMD0    = 8'h95;
  localparam logic [7:0] CRC_CMD8    = 8'h87;
  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] DRESP_OK    = 8'h05;
  localparam logic [7:0] DRESP_MASK  = 8'h1F;
  localparam logic [7:0] R7_ECHO     = 8'hAA;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] sector;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } in_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select_high;
    logic       want_write_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       wait_tick;
    logic       done_res;
    logic       failed;
    logic [2:0] card_kind;
  } out_word_t;

endpackage

// ===== rtl/sdsh_stream_if.sv =====
// ----------------------------------------------------------------------------
// SD SPI host sequencer stream interface
// Valid/ready channel that carries one word of a given type.
// ----------------------------------------------------------------------------
interface sdsh_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sd_card_spi_host_sequencer.sv =====
// ----------------------------------------------------------------------------
// SD card SPI-mode host sequencer
// Steps the SD SPI protocol one byte exchange per input word.
//
// Channel  Dir  Handshake     Word
// in_      in   valid/ready   cmd, sector, rx_byte, write_byte
// out_     out  valid/ready   one result word per input word
// cfg_     in   APB read/write poll limits
//
// Each word is processed into the result register, so one word per cycle
// is sustained while the skid is empty. The result register and a one-word
// skid register decouple the sides; input ready depends only on the skid.
// Reset is synchronous and restores the register defaults and idle state.
// ----------------------------------------------------------------------------
module sd_card_spi_host_sequencer #(
  parameter int unsigned BLOCK_BYTES = sdsh_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned IDLE_BYTES  = sdsh_pkg::IDLE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sdsh_stream_if.sink   in_ch,
  sdsh_stream_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sdsh_pkg::*;

  localparam int CW = $clog2(BLOCK_BYTES + 1);

  logic [15:0] init_lim_r, tok_lim_r, busy_lim_r;
  logic [3:0]  resp_lim_r;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [CW-1:0] bcnt_r, bcnt_nxt;
  logic [15:0] poll_r, poll_nxt;
  logic [3:0]  tries_r, tries_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [1:0]  ocr_r, ocr_nxt;
  logic        incmd_r, incmd_nxt, app_r, app_nxt;
  logic        otx_r, otx_nxt, ocs_r, ocs_nxt, owant_r, owant_nxt, otick_r, otick_nxt;
  logic [7:0]  obyte_r, obyte_nxt;

  out_word_t res, main_r, skid_r;
  logic main_v_r, skid_v_r;
  logic acc;

  assign cfg_pready = 1'b1;
  always_comb begin
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_INIT_POLL:  cfg_prdata = {16'd0, init_lim_r};
      REG_TOKEN_POLL: cfg_prdata = {16'd0, tok_lim_r};
      REG_BUSY_POLL:  cfg_prdata = {16'd0, busy_lim_r};
      REG_RESP_POLL:  cfg_prdata = {28'd0, resp_lim_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_lim_r <= 16'd10000;
      tok_lim_r  <= 16'd40000;
      busy_lim_r <= 16'd5000;
      resp_lim_r <= 4'd10;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      case (reg_idx_t'(cfg_paddr[3:2]))
        REG_INIT_POLL:  init_lim_r <= cfg_pwdata[15:0];
        REG_TOKEN_POLL: tok_lim_r  <= cfg_pwdata[15:0];
        REG_BUSY_POLL:  busy_lim_r <= cfg_pwdata[15:0];
        REG_RESP_POLL:  resp_lim_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !skid_v_r;
  assign acc = in_ch.valid && in_ch.ready;

  function automatic logic [7:0] frame_byte(input logic [CW-1:0] idx, input logic app,
                                            input logic [7:0] pend, input logic [31:0] arg0);
    logic [7:0]  code;
    logic [31:0] arg;
    code = app ? CODE_CMD55 : {1'b0, pend[6:0]};
    arg  = app ? 32'd0 : arg0;
    case (idx)
      CW'(1):  frame_byte = code;
      CW'(2):  frame_byte = arg[31:24];
      CW'(3):  frame_byte = arg[23:16];
      CW'(4):  frame_byte = arg[15:8];
      CW'(5):  frame_byte = arg[7:0];
      default: frame_byte = (code == CODE_CMD0) ? CRC_CMD0 :
                            ((code == CODE_CMD8) ? CRC_CMD8 : 8'h01);
    endcase
  endfunction

  always_comb begin
    in_word_t   w;
    logic       rv, done, fl;
    logic [7:0] rb;
    logic       have_res;
    logic [7:0] rsp;
    logic [15:0] pdec;

    w = in_ch.data;
    phase_nxt = phase_r; kind_nxt = kind_r; addr_nxt = addr_r; bcnt_nxt = bcnt_r;
    poll_nxt = poll_r; tries_nxt = tries_r; pend_nxt = pend_r; ocr_nxt = ocr_r;
    incmd_nxt = incmd_r; app_nxt = app_r;
    otx_nxt = otx_r; obyte_nxt = obyte_r; ocs_nxt = ocs_r; owant_nxt = owant_r;
    otick_nxt = otick_r;
    rv = 1'b0; rb = 8'd0; done = 1'b0; fl = 1'b0;
    have_res = 1'b0; rsp = 8'd0;
    pdec = poll_r - 16'd1;

    if (phase_r == PH_IDLE) begin
      otx_nxt = 1'b0; obyte_nxt = 8'd0; ocs_nxt = 1'b1; owant_nxt = 1'b0; otick_nxt = 1'b0;
      if (w.cmd == CMD_INIT) begin
        kind_nxt = KIND_NONE; incmd_nxt = 1'b0; app_nxt = 1'b0;
        phase_nxt = PH_PRE; bcnt_nxt = '0;
        otx_nxt = 1'b1; obyte_nxt = 8'hFF; ocs_nxt = 1'b1;
      end else if (w.cmd == CMD_READ || w.cmd == CMD_WRITE) begin
        phase_nxt = (w.cmd == CMD_READ) ? PH_RDC : PH_WRC;
        pend_nxt  = (w.cmd == CMD_READ) ? CODE_CMD17 : CODE_CMD24;
        addr_nxt  = (kind_r == KIND_SD2_BL) ? w.sector : {w.sector[22:0], 9'd0};
        app_nxt = 1'b0; incmd_nxt = 1'b1; bcnt_nxt = '0;
        otx_nxt = 1'b1; obyte_nxt = 8'hFF; ocs_nxt = 1'b0;
      end
    end else if (phase_r == PH_HCS_T || phase_r == PH_LOOP_T || phase_r == PH_BUSY_T) begin
      if (w.cmd == CMD_TICK) begin
        poll_nxt = pdec;
        otx_nxt = 1'b1; obyte_nxt = 8'hFF; ocs_nxt = 1'b0; owant_nxt = 1'b0; otick_nxt = 1'b0;
        if (pdec == 16'd0) begin
          phase_nxt = PH_IDLE; incmd_nxt = 1'b0; app_nxt = 1'b0;
          otx_nxt = 1'b0; obyte_nxt = 8'd0; ocs_nxt = 1'b1; done = 1'b1; fl = 1'b1;
          if (phase_r != PH_BUSY_T) kind_nxt = KIND_NONE;
        end else if (phase_r == PH_BUSY_T) begin
          phase_nxt = PH_BUSY;
        end else begin
          phase_nxt = (phase_r == PH_HCS_T) ? PH_HCS : PH_LOOP;
          pend_nxt  = (phase_r == PH_HCS_T || kind_r == KIND_SD1) ?
                      CODE_ACMD41 : CODE_CMD1;
          addr_nxt  = (phase_r == PH_HCS_T) ? ARG_HCS : 32'd0;
          app_nxt = (phase_r == PH_HCS_T || kind_r == KIND_SD1);
          incmd_nxt = 1'b1; bcnt_nxt = '0;
        end
      end
    end else if (w.cmd == CMD_RX) begin
      // Default request: another 0xFF with the card selected.
      otx_nxt = 1'b1; obyte_nxt = 8'hFF; ocs_nxt = 1'b0; owant_nxt = 1'b0; otick_nxt = 1'b0;
      if (incmd_r) begin
        if (bcnt_r < CW'(6)) begin
          bcnt_nxt = bcnt_r + CW'(1);
          obyte_nxt = frame_byte(bcnt_r + CW'(1), app_r, pend_r, addr_r);
        end else if (bcnt_r == CW'(6)) begin
          bcnt_nxt = CW'(7); tries_nxt = 4'd0;
        end else if (w.rx_byte[7] && tries_r < resp_lim_r) begin
          tries_nxt = tries_r + 4'd1;
        end else if (app_r && w.rx_byte <= 8'd1) begin
          app_nxt = 1'b0; bcnt_nxt = '0;
        end else begin
          app_nxt = 1'b0; incmd_nxt = 1'b0; have_res = 1'b1; rsp = w.rx_byte;
        end
      end else begin
        case (phase_r)
          PH_PRE: begin
            bcnt_nxt = bcnt_r + CW'(1);
            if (bcnt_r + CW'(1) < CW'(IDLE_BYTES)) ocs_nxt = 1'b1;
            else begin
              phase_nxt = PH_GO; pend_nxt = CODE_CMD0; addr_nxt = 32'd0;
              app_nxt = 1'b0; incmd_nxt = 1'b1; bcnt_nxt = '0;
            end
          end
          PH_R7: begin
            if (bcnt_r == CW'(2) && w.rx_byte == 8'h01) ocr_nxt[1] = 1'b1;
            if (bcnt_r >= CW'(3)) begin
              if ((ocr_r[1] || (bcnt_r == CW'(2) && w.rx_byte == 8'h01))
                  && w.rx_byte == R7_ECHO && init_lim_r != 16'd0) begin
                poll_nxt = init_lim_r;
                phase_nxt = PH_HCS; pend_nxt = CODE_ACMD41; addr_nxt = ARG_HCS;
                app_nxt = 1'b1; incmd_nxt = 1'b1; bcnt_nxt = '0;
              end else begin
                if ((ocr_r[1]) && w.rx_byte == R7_ECHO) poll_nxt = init_lim_r;
                kind_nxt = KIND_NONE; phase_nxt = PH_IDLE; done = 1'b1; fl = 1'b1;
                otx_nxt = 1'b0; obyte_nxt = 8'd0; ocs_nxt = 1'b1;
              end
            end else bcnt_nxt = bcnt_r + CW'(1);
          end
          PH_OCR: begin
            if (bcnt_r == '0 && w.rx_byte[6]) ocr_nxt[0] = 1'b1;
            if (bcnt_r >= CW'(3)) begin
              kind_nxt = ocr_r[0] ? KIND_SD2_BL : KIND_SD2_BY;
              phase_nxt = PH_IDLE; done = 1'b1;
              otx_nxt = 1'b0; obyte_nxt = 8'd0; ocs_nxt = 1'b1;
            end else bcnt_nxt = bcnt_r + CW'(1);
          end
          PH_RDTOK: begin
            if (w.rx_byte == 8'hFF && poll_r != 16'd0) poll_nxt = pdec;
            else if (w.rx_byte == TOKEN_START) begin
              phase_nxt = PH_RDDAT; bcnt_nxt = '0;
            end else begin
              phase_nxt = PH_IDLE; done = 1'b1; fl = 1'b1;
              otx_nxt = 1'b0; obyte_nxt = 8'd0; ocs_nxt = 1'b1;
            end
          end
          PH_RDDAT: begin
            rv = 1'b1; rb = w.rx_byte;
            bcnt_nxt = bcnt_r + CW'(1);
            if (bcnt_r + CW'(1) >= CW'(BLOCK_BYTES)) begin
              phase_nxt = PH_RDCRC; bcnt_nxt = '0;
            end
          end
          PH_RDCRC: begin
            if (bcnt_r == '0) bcnt_nxt = CW'(1);
            else begin
              phase_nxt = PH_IDLE; done = 1'b1;
              otx_nxt = 1'b0; obyte_nxt = 8'd0; ocs_nxt = 1'b1;
            end
          end
          PH_WRGAP: begin
            phase_nxt = PH_WRTOK; obyte_nxt = TOKEN_START; owant_nxt = 1'b1;
          end
          PH_WRTOK: begin
            phase_nxt = PH_WRDAT; bcnt_nxt = CW'(1);
            obyte_nxt = w.write_byte; owant_nxt = (BLOCK_BYTES > 1);
          end
          PH_WRDAT: begin
            if (bcnt_r < CW'(BLOCK_BYTES)) begin
              bcnt_nxt = bcnt_r + CW'(1);
              obyte_nxt = w.write_byte;
              owant_nxt = (bcnt_r + CW'(1)) < CW'(BLOCK_BYTES);
            end else begin
              phase_nxt = PH_WRCRC; bcnt_nxt = '0; obyte_nxt = 8'h00;
            end
          end
          PH_WRCRC: begin
            if (bcnt_r == '0) begin
              bcnt_nxt = CW'(1); obyte_nxt = 8'h00;
            end else phase_nxt = PH_WRRSP;
          end
          PH_WRRSP: begin
            if ((w.rx_byte & DRESP_MASK) == DRESP_OK && busy_lim_r != 16'd0) begin
              poll_nxt = busy_lim_r; phase_nxt = PH_BUSY;
            end else begin
              if ((w.rx_byte & DRESP_MASK) == DRESP_OK) poll_nxt = busy_lim_r;
              phase_nxt = PH_IDLE; done = 1'b1; fl = 1'b1;
              otx_nxt = 1'b0; obyte_nxt = 8'd0; ocs_nxt = 1'b1;
            end
          end
          default: begin
            if (w.rx_byte == 8'hFF) begin
              phase_nxt = PH_IDLE; done = 1'b1;
              otx_nxt = 1'b0; obyte_nxt = 8'd0; ocs_nxt = 1'b1;
            end else begin
              phase_nxt = PH_BUSY_T;
              otx_nxt = 1'b0; obyte_nxt = 8'd0; otick_nxt = 1'b1;
            end
          end
        endcase
      end

      if (have_res) begin
        case (phase_r)
          PH_GO: begin
            if (rsp == 8'd1) begin
              phase_nxt = PH_IFC; pend_nxt = CODE_CMD8; addr_nxt = ARG_IFC;
              app_nxt = 1'b0; incmd_nxt = 1'b1; bcnt_nxt = '0;
            end else begin
              kind_nxt = KIND_NONE; phase_nxt = PH_IDLE; done = 1'b1; fl = 1'b1;
            end
          end
          PH_IFC: begin
            if (rsp == 8'd1) begin
              phase_nxt = PH_R7; bcnt_nxt = '0; ocr_nxt = 2'd0;
            end else begin
              phase_nxt = PH_PROBE; pend_nxt = CODE_ACMD41; addr_nxt = 32'd0;
              app_nxt = 1'b1; incmd_nxt = 1'b1; bcnt_nxt = '0;
            end
          end
          PH_PROBE: begin
            kind_nxt = (rsp <= 8'd1) ? KIND_SD1 : KIND_MMC;
            poll_nxt = init_lim_r;
            if (init_lim_r == 16'd0) begin
              kind_nxt = KIND_NONE; phase_nxt = PH_IDLE; done = 1'b1; fl = 1'b1;
            end else begin
              phase_nxt = PH_LOOP; addr_nxt = 32'd0; bcnt_nxt = '0; incmd_nxt = 1'b1;
              pend_nxt = (rsp <= 8'd1) ? CODE_ACMD41 : CODE_CMD1;
              app_nxt = (rsp <= 8'd1);
            end
          end
          PH_LOOP: begin
            if (rsp == 8'd0) begin
              phase_nxt = PH_BLEN; pend_nxt = CODE_CMD16; addr_nxt = 32'(BLOCK_BYTES);
              app_nxt = 1'b0; incmd_nxt = 1'b1; bcnt_nxt = '0;
            end else begin
              phase_nxt = PH_LOOP_T; otx_nxt = 1'b0; obyte_nxt = 8'd0; otick_nxt = 1'b1;
            end
          end
          PH_BLEN: begin
            phase_nxt = PH_IDLE; done = 1'b1; fl = (rsp != 8'd0);
            if (rsp != 8'd0) kind_nxt = KIND_NONE;
          end
          PH_HCS: begin
            if (rsp == 8'd0) begin
              phase_nxt = PH_OCRC; pend_nxt = CODE_CMD58; addr_nxt = 32'd0;
              app_nxt = 1'b0; incmd_nxt = 1'b1; bcnt_nxt = '0;
            end else begin
              phase_nxt = PH_HCS_T; otx_nxt = 1'b0; obyte_nxt = 8'd0; otick_nxt = 1'b1;
            end
          end
          PH_OCRC: begin
            if (rsp == 8'd0) begin
              phase_nxt = PH_OCR; bcnt_nxt = '0; ocr_nxt = 2'd0;
            end else begin
              kind_nxt = KIND_NONE; phase_nxt = PH_IDLE; done = 1'b1; fl = 1'b1;
            end
          end
          PH_RDC: begin
            if (rsp == 8'd0) begin
              phase_nxt = PH_RDTOK; poll_nxt = tok_lim_r;
            end else begin
              phase_nxt = PH_IDLE; done = 1'b1; fl = 1'b1;
            end
          end
          default: begin
            if (rsp == 8'd0) phase_nxt = PH_WRGAP;
            else begin
              phase_nxt = PH_IDLE; done = 1'b1; fl = 1'b1;
            end
          end
        endcase
        if (done) begin
          otx_nxt = 1'b0; obyte_nxt = 8'd0; ocs_nxt = 1'b1; app_nxt = 1'b0;
          incmd_nxt = 1'b0;
        end
      end
    end

    res.tx_valid = otx_nxt;
    res.tx_byte = obyte_nxt;
    res.chip_select_high = ocs_nxt;
    res.want_write_byte = owant_nxt;
    res.read_valid = rv;
    res.read_byte = rb;
    res.wait_tick = otick_nxt;
    res.done_res = done;
    res.failed = fl;
    res.card_kind = kind_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; kind_r <= KIND_NONE; addr_r <= 32'd0; bcnt_r <= '0;
      poll_r <= 16'd0; tries_r <= 4'd0; pend_r <= 8'd0; ocr_r <= 2'd0;
      incmd_r <= 1'b0; app_r <= 1'b0;
      otx_r <= 1'b0; obyte_r <= 8'd0; ocs_r <= 1'b1; owant_r <= 1'b0; otick_r <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt; kind_r <= kind_nxt; addr_r <= addr_nxt; bcnt_r <= bcnt_nxt;
      poll_r <= poll_nxt; tries_r <= tries_nxt; pend_r <= pend_nxt; ocr_r <= ocr_nxt;
      incmd_r <= incmd_nxt; app_r <= app_nxt;
      otx_r <= otx_nxt; obyte_r <= obyte_nxt; ocs_r <= ocs_nxt; owant_r <= owant_nxt;
      otick_r <= otick_nxt;
    end
  end

  // Output register with a one-word skid stage behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!main_v_r || out_ch.ready) begin
        if (skid_v_r) begin
          main_v_r <= 1'b1; main_r <= skid_r; skid_v_r <= acc;
          if (acc) skid_r <= res;
        end else begin
          main_v_r <= acc;
          if (acc) main_r <= res;
        end
      end else if (acc) begin
        skid_v_r <= 1'b1; skid_r <= res;
      end
    end
  end

  assign out_ch.valid = main_v_r;
  assign out_ch.data  = main_r;

  a_skid_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(main_v_r && !out_ch.ready)) else $error("skid misuse");
  a_tick_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    otick_r |-> !otx_r) else $error("tick and byte both requested");
  a_idle_cs_high: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> ocs_r && !otx_r) else $error("idle with card selected");

endmodule
